FILE: design/btdi_pkg.sv
// Shared types and constants for the brightness to dim interpolator.
`default_nettype none

package btdi_pkg;

    localparam int TABLE_DEPTH_DEF = 21;

    localparam int LEVEL_W  = 11;
    localparam int ALPHA_W  = 8;
    localparam int KNOT_W   = LEVEL_W + ALPHA_W;
    localparam int X_W      = 10;
    localparam int PCT_W    = 7;
    localparam int RESULT_W = 8;
    localparam int AINT_W   = 13;

    localparam int MUL_A_W  = 12;
    localparam int MUL_B_W  = 11;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam int DIVD_W     = 24;
    localparam int DVS_W      = 11;
    localparam int DIV_CYCLES = DIVD_W / 2;
    localparam int CNT_W      = 4;

    localparam logic [PCT_W-1:0]    DIM_RESET   = PCT_W'(70);
    localparam logic [DVS_W-1:0]    PCT_DIVISOR = DVS_W'(100);
    localparam logic [RESULT_W-1:0] RESULT_MAX  = RESULT_W'(255);

    localparam logic REQ_CONVERT = 1'b0;
    localparam logic REQ_WRITE   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_PREP,
        S_MUL1,
        S_MUL2,
        S_SCALE,
        S_DIV
    } state_t;

    typedef enum logic [1:0] {
        OP_LIN,
        OP_SUB_DY,
        OP_SUB_DX,
        OP_PCT
    } div_op_t;

endpackage

`default_nettype wire

FILE: design/brightness_to_dim_interpolator.sv
// Top level: knot table, serial search and shared multiply/divide datapath.
//
//  channel   | ports                                                    | handshake
//  ----------+----------------------------------------------------------+-----------------
//  request   | req_type brightness knot_index knot_level knot_alpha     | start & !busy
//  result    | dim_amount                                               | done, one cycle
//  config    | dim_percent                                              | cfg_valid & cfg_ready
//
//  A knot write finishes at the edge that accepts it; busy stays low.
//  A convert beat walks the knot table one entry a cycle, then runs up to four
//  divisions on one radix-4 divider.
//  Reset restores dim_percent to 70; the knot table holds nothing until written.
//  done pulses for one cycle and cannot be stalled; a new start is taken in that cycle.
`default_nettype none

module brightness_to_dim_interpolator
    import btdi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                req_type,
    input  wire logic [7:0]          brightness,
    input  wire logic [4:0]          knot_index,
    input  wire logic [LEVEL_W-1:0]  knot_level,
    input  wire logic [ALPHA_W-1:0]  knot_alpha,
    output logic                     done,
    output logic [RESULT_W-1:0]      dim_amount,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [PCT_W-1:0]    dim_percent
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [KNOT_W-1:0] knot_mem [TABLE_DEPTH];

    state_t              state_reg, state_next;
    div_op_t             op_reg, op_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [KNOT_W-1:0]   rd_data_reg;
    logic [KNOT_W-1:0]   prev_reg, prev_next;
    logic [KNOT_W-1:0]   cur_reg, cur_next;
    logic [X_W-1:0]      d1_reg, d1_next;
    logic [LEVEL_W-1:0]  dx_reg, dx_next;
    logic [LEVEL_W-1:0]  d2m_reg, d2m_next;
    logic [ALPHA_W-1:0]  dym_reg, dym_next;
    logic                neg_reg, neg_next;
    logic [ALPHA_W:0]    lin_reg, lin_next;
    logic [AINT_W-1:0]   alpha_reg, alpha_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0]   quo_reg, quo_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PCT_W-1:0]    dim_reg;
    logic [RESULT_W-1:0] out_reg, out_next;
    logic                done_reg, done_next;

    logic                accept;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [1:0]          x_frac;
    logic [X_W-1:0]      x_scaled;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;

    logic [DVS_W:0]      div_t1, div_t2;
    logic                div_ge1, div_ge2;
    logic [DVS_W-1:0]    div_r1, div_r2;
    logic [DIVD_W-1:0]   div_q1, div_q2;
    logic                div_last;

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign dim_amount = out_reg;
    assign cfg_ready  = 1'b1;

    assign accept  = start && !busy;
    assign wr_en   = accept && (req_type == REQ_WRITE) && (32'(knot_index) < TABLE_DEPTH);
    assign wr_addr = IDX_W'(knot_index);

    // x = b*1023/255 = 4b + b/85
    assign x_frac   = 2'((brightness >= 8'd85)) + 2'((brightness >= 8'd170))
                    + 2'((brightness == 8'd255));
    assign x_scaled = {brightness, 2'b00} + {8'd0, x_frac};

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // two restoring steps a cycle
    assign div_t1  = {rem_reg, quo_reg[DIVD_W-1]};
    assign div_ge1 = (div_t1 >= {1'b0, dvs_reg});
    assign div_r1  = div_ge1 ? DVS_W'(div_t1 - {1'b0, dvs_reg}) : DVS_W'(div_t1);
    assign div_q1  = {quo_reg[DIVD_W-2:0], div_ge1};
    assign div_t2  = {div_r1, div_q1[DIVD_W-1]};
    assign div_ge2 = (div_t2 >= {1'b0, dvs_reg});
    assign div_r2  = div_ge2 ? DVS_W'(div_t2 - {1'b0, dvs_reg}) : DVS_W'(div_t2);
    assign div_q2  = {div_q1[DIVD_W-2:0], div_ge2};
    assign div_last = (cnt_reg == CNT_W'(DIV_CYCLES - 1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            knot_mem[wr_addr] <= {knot_level, knot_alpha};
        end
        rd_data_reg <= knot_mem[addr_reg];
    end

    always_comb
    begin
        logic [LEVEL_W-1:0]  xa;
        logic [LEVEL_W-1:0]  xb;
        logic [ALPHA_W:0]    dy;
        logic [ALPHA_W:0]    lin_sum;
        logic [AINT_W-1:0]   mag;
        logic [AINT_W-1:0]   term;

        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        addr_next  = addr_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        d1_next    = d1_reg;
        dx_next    = dx_reg;
        d2m_next   = d2m_reg;
        dym_next   = dym_reg;
        neg_next   = neg_reg;
        lin_next   = lin_reg;
        alpha_next = alpha_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;

        xa      = prev_reg[KNOT_W-1:ALPHA_W];
        xb      = cur_reg[KNOT_W-1:ALPHA_W];
        dy      = {1'b0, cur_reg[ALPHA_W-1:0]} - {1'b0, prev_reg[ALPHA_W-1:0]};
        lin_sum = div_q2[ALPHA_W:0] + (ALPHA_W+1)'(1);
        mag     = AINT_W'(lin_reg) + AINT_W'(div_q2[MUL_A_W-1:0]);
        term    = neg_reg ? (AINT_W'(0) - mag) : mag;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_CONVERT))
                begin
                    x_next     = x_scaled;
                    addr_next  = '0;
                    idx_next   = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                addr_next  = addr_reg + IDX_W'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_data_reg[KNOT_W-1:ALPHA_W] >= {1'b0, x_reg})
                begin
                    if (idx_reg == '0)
                    begin
                        alpha_next = AINT_W'(rd_data_reg[ALPHA_W-1:0]);
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        cur_next   = rd_data_reg;
                        state_next = S_PREP;
                    end
                end
                else
                begin
                    prev_next = rd_data_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        alpha_next = AINT_W'(rd_data_reg[ALPHA_W-1:0]);
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        if (addr_reg != LAST_IDX)
                        begin
                            addr_next = addr_reg + IDX_W'(1);
                        end
                    end
                end
            end
            S_PREP:
            begin
                d1_next  = X_W'({1'b0, x_reg} - xa);
                dx_next  = xb - xa;
                d2m_next = xb - {1'b0, x_reg};
                neg_next = dy[ALPHA_W];
                dym_next = dy[ALPHA_W] ? ALPHA_W'(~dy + 1'b1) : dy[ALPHA_W-1:0];
                if (dy == '0)
                begin
                    alpha_next = AINT_W'(prev_reg[ALPHA_W-1:0]);
                    state_next = S_SCALE;
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                mul_a      = MUL_A_W'(dym_reg);
                mul_b      = MUL_B_W'(d1_reg);
                quo_next   = {prod, 1'b0};
                dvs_next   = dx_reg;
                rem_next   = '0;
                cnt_next   = '0;
                op_next    = OP_LIN;
                state_next = S_DIV;
            end
            S_MUL2:
            begin
                mul_a      = MUL_A_W'(d1_reg);
                mul_b      = d2m_reg;
                quo_next   = {prod, 1'b0};
                dvs_next   = DVS_W'(dym_reg);
                rem_next   = '0;
                cnt_next   = '0;
                op_next    = OP_SUB_DY;
                state_next = S_DIV;
            end
            S_SCALE:
            begin
                if (alpha_reg[AINT_W-1])
                begin
                    out_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mul_a      = alpha_reg[MUL_A_W-1:0];
                    mul_b      = MUL_B_W'(dim_reg);
                    quo_next   = DIVD_W'(prod);
                    dvs_next   = PCT_DIVISOR;
                    rem_next   = '0;
                    cnt_next   = '0;
                    op_next    = OP_PCT;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = div_r2;
                quo_next = div_q2;
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    case (op_reg)
                        OP_LIN:
                        begin
                            lin_next   = {1'b0, lin_sum[ALPHA_W:1]};
                            state_next = S_MUL2;
                        end
                        OP_SUB_DY:
                        begin
                            quo_next = div_q2;
                            dvs_next = dx_reg;
                            rem_next = '0;
                            cnt_next = '0;
                            op_next  = OP_SUB_DX;
                        end
                        OP_SUB_DX:
                        begin
                            alpha_next = AINT_W'(prev_reg[ALPHA_W-1:0]) + term;
                            state_next = S_SCALE;
                        end
                        OP_PCT:
                        begin
                            out_next   = (div_q2 > DIVD_W'(RESULT_MAX))
                                       ? RESULT_MAX : div_q2[RESULT_W-1:0];
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            dim_reg   <= DIM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                dim_reg <= dim_percent;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        x_reg     <= x_next;
        addr_reg  <= addr_next;
        idx_reg   <= idx_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        d1_reg    <= d1_next;
        dx_reg    <= dx_next;
        d2m_reg   <= d2m_next;
        dym_reg   <= dym_next;
        neg_reg   <= neg_next;
        lin_reg   <= lin_next;
        alpha_reg <= alpha_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        cnt_reg   <= cnt_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

FILE: bench/brightness_to_dim_interpolator_test.sv
// Testbench for brightness_to_dim_interpolator: random knot tables and conversions.
`timescale 1ns / 100ps

import btdi_pkg::*;

class dim_scoreboard;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic [ALPHA_W-1:0] alpha;
    } knot_t;

    knot_t               knots[TABLE_DEPTH_DEF];
    logic [PCT_W-1:0]    percent;
    logic [RESULT_W-1:0] pending_dims[$];
    int                  mismatches;

    function new();
        percent    = DIM_RESET;
        mismatches = 0;
        for (int k = 0; k < TABLE_DEPTH_DEF; k++)
        begin
            knots[k].level = '0;
            knots[k].alpha = '0;
        end
    endfunction

    function void set_percent(logic [PCT_W-1:0] value);
        percent = value;
    endfunction

    function int pending();
        return pending_dims.size();
    endfunction

    function void note_request(logic rt, logic [7:0] b, logic [4:0] idx,
                               logic [LEVEL_W-1:0] lvl, logic [ALPHA_W-1:0] a);
        longint x, xa, xb, ya, yb, dx, dy, bf, sub, alpha, dim;
        int     i;
        if (rt == REQ_WRITE)
        begin
            if (idx < TABLE_DEPTH_DEF)
            begin
                knots[idx].level = lvl;
                knots[idx].alpha = a;
            end
            return;
        end
        x = longint'(b) * 1023 / 255;
        for (i = 0; i < TABLE_DEPTH_DEF; i++)
            if (longint'(knots[i].level) >= x)
                break;
        if (i == 0)
            alpha = longint'(knots[0].alpha);
        else if (i == TABLE_DEPTH_DEF)
            alpha = longint'(knots[TABLE_DEPTH_DEF-1].alpha);
        else
        begin
            xa    = longint'(knots[i-1].level);
            xb    = longint'(knots[i].level);
            ya    = longint'(knots[i-1].alpha);
            yb    = longint'(knots[i].alpha);
            dx    = xb - xa;
            dy    = yb - ya;
            bf    = 2 * dy * (x - xa) / dx;
            sub   = (dy != 0) ? 2 * (x - xa) * (x - xb) / dy / (xa - xb) : 0;
            alpha = ya + bf / 2 + bf % 2 + sub;
        end
        dim = alpha * longint'(percent) / 100;
        if (dim < 0)
            dim = 0;
        if (dim > 255)
            dim = 255;
        pending_dims.push_back(RESULT_W'(dim));
    endfunction

    function void check_dim(logic [RESULT_W-1:0] got);
        logic [RESULT_W-1:0] want;
        if (pending_dims.size() == 0)
        begin
            $error("dim_amount: unexpected beat, actual %0d", got);
            mismatches++;
            return;
        end
        want = pending_dims.pop_front();
        if (got !== want)
        begin
            $error("dim_amount: expected %0d, actual %0d", want, got);
            mismatches++;
        end
    endfunction

endclass

module brightness_to_dim_interpolator_test;

    localparam int DRAIN_CYCLES = 150;
    localparam logic [ALPHA_W-1:0] RAMP_ALPHA [5] = '{8'd255, 8'd0, 8'd1, 8'd0, 8'd0};
    localparam logic [7:0] DIRECTED_B [12] =
        '{8'd0, 8'd25, 8'd26, 8'd35, 8'd37, 8'd40, 8'd47, 8'd52, 8'd128, 8'd224, 8'd225, 8'd255};

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic [7:0]          brightness;
    logic [4:0]          knot_index;
    logic [LEVEL_W-1:0]  knot_level;
    logic [ALPHA_W-1:0]  knot_alpha;
    logic                done;
    logic [RESULT_W-1:0] dim_amount;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [PCT_W-1:0]    dim_percent;

    bit            steady;
    dim_scoreboard sb = new();

    brightness_to_dim_interpolator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .brightness  (brightness),
        .knot_index  (knot_index),
        .knot_level  (knot_level),
        .knot_alpha  (knot_alpha),
        .done        (done),
        .dim_amount  (dim_amount),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .dim_percent (dim_percent)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (done)
            sb.check_dim(dim_amount);
        if (start && !busy)
            sb.note_request(req_type, brightness, knot_index, knot_level, knot_alpha);
        if (cfg_valid && cfg_ready)
            sb.set_percent(dim_percent);
    end

    task automatic pace();
        int gap;
        if (!steady && $urandom_range(0, 99) < 31)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic rt, input logic [7:0] b, input logic [4:0] idx,
                             input logic [LEVEL_W-1:0] lvl, input logic [ALPHA_W-1:0] a);
        start      <= 1'b1;
        req_type   <= rt;
        brightness <= b;
        knot_index <= idx;
        knot_level <= lvl;
        knot_alpha <= a;
        // hold the beat until busy drops
        do @(posedge clk); while (busy);
        pace();
    endtask

    task automatic write_percent(input logic [PCT_W-1:0] value);
        cfg_valid   <= 1'b1;
        dim_percent <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic finish_phase();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_random_table();
        int shape, level, spread, alpha, step;
        shape  = $urandom_range(0, 99);
        level  = $urandom_range(0, 120);
        spread = $urandom_range(5, 110);
        alpha  = $urandom_range(0, 255);
        for (int k = 0; k < TABLE_DEPTH_DEF; k++)
        begin
            step = $urandom_range(0, spread);
            if (shape < 25)
                level = $urandom_range(0, 2047);
            else if (k > 0)
                level = (level + step > 2047) ? 2047 : level + step;
            if (shape % 2 == 0)
                alpha = $urandom_range(0, 255);
            else
            begin
                alpha = alpha + int'($urandom_range(0, 6)) - 3;
                alpha = (alpha < 0) ? 0 : (alpha > 255) ? 255 : alpha;
            end
            send_item(REQ_WRITE, 8'($urandom), 5'(k), LEVEL_W'(level), ALPHA_W'(alpha));
        end
    endtask

    task automatic run_random(input int count);
        int n, pick;
        logic [7:0] b;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                load_random_table();
                n += TABLE_DEPTH_DEF;
            end
            else if (pick < 7)
            begin
                send_item(REQ_WRITE, 8'($urandom), 5'($urandom_range(0, TABLE_DEPTH_DEF - 1)),
                          LEVEL_W'($urandom_range(0, 2047)), ALPHA_W'($urandom));
                n++;
            end
            else if (pick < 9)
                send_item(REQ_WRITE, 8'($urandom), 5'($urandom_range(TABLE_DEPTH_DEF, 31)),
                          LEVEL_W'($urandom), ALPHA_W'($urandom));
            else
            begin
                b = (pick < 15) ? 8'd0 : (pick < 21) ? 8'd255 : 8'($urandom);
                send_item(REQ_CONVERT, b, 5'($urandom), LEVEL_W'($urandom), ALPHA_W'($urandom));
                n++;
            end
        end
    endtask

    initial
    begin
        int phase_pct[5];
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_CONVERT;
        brightness  = '0;
        knot_index  = '0;
        knot_level  = '0;
        knot_alpha  = '0;
        cfg_valid   = 1'b0;
        dim_percent = DIM_RESET;
        steady      = 1'b0;
        phase_pct   = '{0, 127, 100, 1, 0};
        phase_pct[4] = $urandom_range(0, 127);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every slot before the first conversion
        for (int k = 0; k < TABLE_DEPTH_DEF; k++)
            send_item(REQ_WRITE, 8'd0, 5'(k), LEVEL_W'(100 + 40 * k), RAMP_ALPHA[k % 5]);
        send_item(REQ_WRITE, 8'hFF, 5'd31, 11'h7FF, 8'hFF);
        send_item(REQ_WRITE, 8'h00, 5'd21, 11'h000, 8'h00);
        foreach (DIRECTED_B[k])
            send_item(REQ_CONVERT, DIRECTED_B[k], 5'h1F, 11'h7FF, 8'hFF);

        foreach (phase_pct[p])
        begin
            finish_phase();
            write_percent(PCT_W'(phase_pct[p]));
            steady = (p == 2);
            run_random(260);
        end
        finish_phase();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("brightness_to_dim_interpolator test passed");
        else
            $display("brightness_to_dim_interpolator test failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("brightness_to_dim_interpolator test failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/btdi_pkg.sv
design/brightness_to_dim_interpolator.sv
bench/brightness_to_dim_interpolator_test.sv
